// ===== hw/rtl/stable_priority_queue_top_macros.svh =====
// Assertion macros shared by the stable priority queue modules.
// The using module must have clk and rst_n in scope; no other dependencies.
`ifndef STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/spq_pkg.sv =====
// Types and constants for the stable priority queue.
// No dependencies; used by the interfaces, controller, datapath and top level.
package spq_pkg;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned KIND_W   = 8;
  localparam int unsigned PRIO_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_DUP   = 3'd1,
    STAT_NULL  = 3'd2,
    STAT_FULL  = 3'd3,
    STAT_EMPTY = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EVAL = 1'b1
  } spq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the request word and the per-cell compares
    logic commit;   // update the cells and load the output register
  } spq_cmd_t;

endpackage

// ===== hw/rtl/spq_if.sv =====
// Valid/ready channel interfaces for the request and result words.
// Depends on spq_pkg for field widths.
interface spq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic [spq_pkg::ID_W-1:0]          item_id;
  logic [spq_pkg::KIND_W-1:0]        item_kind;
  logic signed [spq_pkg::PRIO_W-1:0] priority_req;

  modport source (output valid, action, item_id, item_kind, priority_req, input ready);
  modport sink   (input valid, action, item_id, item_kind, priority_req, output ready);
endinterface

interface spq_out_if;
  logic                              valid;
  logic                              ready;
  logic [spq_pkg::STATUS_W-1:0]      status;
  logic [spq_pkg::COUNT_W-1:0]       count;
  logic [spq_pkg::ID_W-1:0]          out_item;
  logic [spq_pkg::KIND_W-1:0]        out_kind;
  logic signed [spq_pkg::PRIO_W-1:0] out_priority;

  modport source (output valid, status, count, out_item, out_kind, out_priority, input ready);
  modport sink   (input valid, status, count, out_item, out_kind, out_priority, output ready);
endinterface

// ===== hw/rtl/stable_priority_queue_top.sv =====
// Top level of the stable priority queue; joins controller and datapath.
// Depends on spq_pkg, spq_if.sv, spq_ctrl and spq_dp.

// Bounded priority queue of CAPACITY entries (2 to 1024), smaller priority
// first, equal priorities in arrival order. Each request word has a capture
// step, which registers the handle and priority compares of every cell
// against the word, and a commit step, which checks null, duplicate and full,
// shifts the cell row and loads the result register. The result register
// decouples the output; the next request is taken while a result waits, but
// its commit waits until that result has been taken. No clearing pass is
// needed after reset. The count field wraps modulo 32 for capacities above 31.
module stable_priority_queue_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);

  spq_pkg::spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  spq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_action       (in_ch.action),
    .in_item_id      (in_ch.item_id),
    .in_item_kind    (in_ch.item_kind),
    .in_priority_req (in_ch.priority_req),
    .out_status      (out_ch.status),
    .out_count       (out_ch.count),
    .out_item        (out_ch.out_item),
    .out_kind        (out_ch.out_kind),
    .out_priority    (out_ch.out_priority)
  );

endmodule

// ===== hw/rtl/spq_ctrl.sv =====
// Controller for the stable priority queue: accepts a request word, then
// commits it once the output register is free. Depends on spq_pkg and the macros.
`include "stable_priority_queue_top_macros.svh"

module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output spq_pkg::spq_cmd_t cmd
);

  spq_pkg::spq_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      spq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = spq_pkg::ST_EVAL;
        end
      end
      spq_pkg::ST_EVAL: begin
        // The queue only changes once the result has somewhere to go.
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `SPQ_ASSERT_NEXT(a_capture_to_eval, cmd.capture, state_r == spq_pkg::ST_EVAL, "capture did not enter evaluation")
  `SPQ_ASSERT_NEXT(a_commit_shows_word, cmd.commit, out_valid_r, "commit did not present a result word")
  `SPQ_ASSERT_NEXT(a_wait_on_stall, (state_r == spq_pkg::ST_EVAL) && out_valid_r && !out_ready, (state_r == spq_pkg::ST_EVAL) && !$past(cmd.commit), "committed while output register was blocked")

endmodule

// ===== hw/rtl/spq_dp.sv =====
// Datapath for the stable priority queue: a sorted row of cells with per-cell
// compares, the occupancy count and the result register. Depends on spq_pkg and the macros.
`include "stable_priority_queue_top_macros.svh"

module spq_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spq_pkg::spq_cmd_t                 cmd,
  input  logic                              in_action,
  input  logic [spq_pkg::ID_W-1:0]          in_item_id,
  input  logic [spq_pkg::KIND_W-1:0]        in_item_kind,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_priority_req,
  output logic [spq_pkg::STATUS_W-1:0]      out_status,
  output logic [spq_pkg::COUNT_W-1:0]       out_count,
  output logic [spq_pkg::ID_W-1:0]          out_item,
  output logic [spq_pkg::KIND_W-1:0]        out_kind,
  output logic signed [spq_pkg::PRIO_W-1:0] out_priority
);

  localparam int unsigned OCC_W = $clog2(CAPACITY + 1);

  // Cell storage; each cell reads only itself and its two neighbors.
  logic [spq_pkg::ID_W-1:0]          cell_handle_r [CAPACITY];
  logic [spq_pkg::KIND_W-1:0]        cell_kind_r   [CAPACITY];
  logic signed [spq_pkg::PRIO_W-1:0] cell_prio_r   [CAPACITY];
  logic [OCC_W-1:0]                  occ_r, occ_nxt;

  // Request word and per-cell compare results, taken at capture.
  logic                              req_action_r;
  logic [spq_pkg::ID_W-1:0]          req_id_r;
  logic [spq_pkg::KIND_W-1:0]        req_kind_r;
  logic signed [spq_pkg::PRIO_W-1:0] req_prio_r;
  logic [CAPACITY-1:0]               match_r;
  logic [CAPACITY-1:0]               le_r;

  logic [CAPACITY-1:0]               valid;
  logic [CAPACITY-1:0]               keep;
  logic                              is_null, is_dup, is_full, is_empty;
  logic                              ins_ok, rem_ok;
  spq_pkg::status_t                  status;
  logic [OCC_W+spq_pkg::COUNT_W-1:0] count_ext;

  logic [spq_pkg::STATUS_W-1:0]      out_status_r;
  logic [spq_pkg::COUNT_W-1:0]       out_count_r;
  logic [spq_pkg::ID_W-1:0]          out_item_r;
  logic [spq_pkg::KIND_W-1:0]        out_kind_r;
  logic signed [spq_pkg::PRIO_W-1:0] out_priority_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_action_r <= in_action;
      req_id_r     <= in_item_id;
      req_kind_r   <= in_item_kind;
      req_prio_r   <= in_priority_req;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cmp
    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        match_r[g] <= (cell_handle_r[g] == in_item_id);
        le_r[g]    <= (cell_prio_r[g] <= in_priority_req);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i] = OCC_W'(i) < occ_r;
    end
  end

  // Cells in front of the insert point are those that are live and not
  // larger than the new priority; since the row is sorted they form a prefix.
  assign keep     = le_r & valid;
  assign is_null  = (req_id_r == '0);
  assign is_dup   = |(match_r & valid);
  assign is_full  = (occ_r == OCC_W'(CAPACITY));
  assign is_empty = (occ_r == '0);
  assign ins_ok   = (req_action_r == spq_pkg::ACT_INSERT) && !is_null && !is_dup && !is_full;
  assign rem_ok   = (req_action_r == spq_pkg::ACT_REMOVE) && !is_empty;

  always_comb begin
    if (req_action_r == spq_pkg::ACT_INSERT) begin
      if (is_null) begin
        status = spq_pkg::STAT_NULL;
      end else if (is_dup) begin
        status = spq_pkg::STAT_DUP;
      end else if (is_full) begin
        status = spq_pkg::STAT_FULL;
      end else begin
        status = spq_pkg::STAT_OK;
      end
    end else begin
      status = is_empty ? spq_pkg::STAT_EMPTY : spq_pkg::STAT_OK;
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (ins_ok) begin
      occ_nxt = occ_r + 1'b1;
    end else if (rem_ok) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  // The count word wraps when the capacity does not fit in it.
  assign count_ext = {{spq_pkg::COUNT_W{1'b0}}, occ_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.commit) begin
      occ_r <= occ_nxt;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [spq_pkg::ID_W-1:0]          up_handle, dn_handle;
    logic [spq_pkg::KIND_W-1:0]        up_kind, dn_kind;
    logic signed [spq_pkg::PRIO_W-1:0] up_prio, dn_prio;
    logic                              front_kept;

    if (g == 0) begin : g_head
      assign up_handle  = cell_handle_r[g];
      assign up_kind    = cell_kind_r[g];
      assign up_prio    = cell_prio_r[g];
      assign front_kept = 1'b1;
    end else begin : g_body
      assign up_handle  = cell_handle_r[g-1];
      assign up_kind    = cell_kind_r[g-1];
      assign up_prio    = cell_prio_r[g-1];
      assign front_kept = keep[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign dn_handle = cell_handle_r[g];
      assign dn_kind   = cell_kind_r[g];
      assign dn_prio   = cell_prio_r[g];
    end else begin : g_inner
      assign dn_handle = cell_handle_r[g+1];
      assign dn_kind   = cell_kind_r[g+1];
      assign dn_prio   = cell_prio_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.commit && ins_ok && !keep[g]) begin
        if (front_kept) begin
          cell_handle_r[g] <= req_id_r;
          cell_kind_r[g]   <= req_kind_r;
          cell_prio_r[g]   <= req_prio_r;
        end else begin
          cell_handle_r[g] <= up_handle;
          cell_kind_r[g]   <= up_kind;
          cell_prio_r[g]   <= up_prio;
        end
      end else if (cmd.commit && rem_ok) begin
        cell_handle_r[g] <= dn_handle;
        cell_kind_r[g]   <= dn_kind;
        cell_prio_r[g]   <= dn_prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= status;
      out_count_r  <= count_ext[spq_pkg::COUNT_W-1:0];
      if (rem_ok) begin
        out_item_r     <= cell_handle_r[0];
        out_kind_r     <= cell_kind_r[0];
        out_priority_r <= cell_prio_r[0];
      end else begin
        out_item_r     <= '0;
        out_kind_r     <= '0;
        out_priority_r <= '0;
      end
    end
  end

  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_item     = out_item_r;
  assign out_kind     = out_kind_r;
  assign out_priority = out_priority_r;

  `SPQ_ASSERT_SAME(a_occ_bound, 1'b1, occ_r <= OCC_W'(CAPACITY), "occupancy exceeds capacity")
  `SPQ_ASSERT_NEXT(a_insert_grows, cmd.commit && ins_ok, occ_r == OCC_W'($past(occ_r) + 1'b1), "insert did not add one entry")
  `SPQ_ASSERT_NEXT(a_remove_shrinks, cmd.commit && rem_ok, occ_r == OCC_W'($past(occ_r) - 1'b1), "remove did not take one entry")

endmodule
